FILE: design/cartridge_bank_mapper_assert.svh
// Assertion macros used by the checker file.
`ifndef CARTRIDGE_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbm assertion failed");

`endif

FILE: design/cbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  localparam int NUM_BANK_REGS = 8;
  localparam int BANK_W        = 8;
  localparam int COUNT_W       = 9;
  localparam int OFFSET_W      = 21;

  localparam logic [1:0] OP_CPU_RD = 2'd0;
  localparam logic [1:0] OP_CPU_WR = 2'd1;
  localparam logic [1:0] OP_PIC_RD = 2'd2;
  localparam logic [1:0] OP_PIC_WR = 2'd3;

  localparam logic [1:0] TGT_NONE   = 2'd0;
  localparam logic [1:0] TGT_PRG_RD = 2'd1;
  localparam logic [1:0] TGT_CHR_RD = 2'd2;
  localparam logic [1:0] TGT_CHR_WR = 2'd3;

  typedef logic [7:0]         cfg_index_t;
  typedef logic [COUNT_W-1:0] cfg_data_t;

  localparam cfg_index_t CFG_PRG_COUNT = 8'd0;
  localparam cfg_index_t CFG_CHR_COUNT = 8'd1;

  localparam logic [BANK_W-1:0]  MASK_1K   = 8'h3F;
  localparam logic [BANK_W-1:0]  MASK_2K   = 8'h3E;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd256;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_value;
  } in_t;

  typedef struct packed {
    logic                claimed;
    logic [1:0]          target;
    logic [OFFSET_W-1:0] rom_offset;
    logic [7:0]          store_value;
  } out_t;

  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] n);
    return (n > COUNT_MAX) ? COUNT_MAX : n;
  endfunction

endpackage

`default_nettype wire

FILE: design/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
`default_nettype none

// Bank-switching cartridge mapper with eight bank registers and a select register.
// Input channel (in_valid/in_ready/in_data): one bus access per beat.
// Output channel (out_valid/out_ready/out_data): exactly one result beat per access,
// in order: claim flag, target kind, ROM byte offset and byte to store.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the program
// bank count, index 1 the character bank count; other indexes are dropped.
// cfg_ready is always high; write only while no access is in flight.
// A mapped read or character access passes through the bit-serial remainder unit that
// reduces the bank number by the bank count, then loads the output register. Writes
// and unmapped accesses go straight to the output register. The block takes no new
// access until the current one is loaded into the output register;
// in_ready is high only while the sequencer is idle.
// A finished result waits in the output register; if the receiver stalls the
// next result holds inside the block and in_ready stays low until it drains.
// Reset (synchronous, active low) clears the bank counts, the select register,
// all bank registers and the output valid.
module cartridge_bank_mapper (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cbm_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cbm_pkg::out_t      out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cbm_pkg::cfg_index_t cfg_index,
  input  cbm_pkg::cfg_data_t  cfg_data
);
  import cbm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [2:0]          sel_r, sel_nxt;
  logic [BANK_W-1:0]   bank_r   [NUM_BANK_REGS];
  logic [BANK_W-1:0]   bank_nxt [NUM_BANK_REGS];
  logic [COUNT_W-1:0]  prg_cnt_r, prg_cnt_nxt;
  logic [COUNT_W-1:0]  chr_cnt_r, chr_cnt_nxt;
  out_t                res_r, res_nxt;
  out_t                out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                is_prg_r, is_prg_nxt;
  logic [12:0]         off_lo_r, off_lo_nxt;

  logic [COUNT_W-1:0]  pc, cc, pc_m1, pc_m2;
  out_t                acc_res;
  logic                need_mod;
  logic                acc_is_prg;
  logic [BANK_W-1:0]   bank_num;
  logic                in_fire;
  logic                out_free;
  logic                mod_done;
  logic [BANK_W-1:0]   mod_rem;
  out_t                fin_res;

  assign pc      = sat_count(prg_cnt_r);
  assign cc      = sat_count(chr_cnt_r);
  assign pc_m1   = pc - 9'd1;
  assign pc_m2   = pc - 9'd2;
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    acc_res    = '0;
    need_mod   = 1'b0;
    acc_is_prg = 1'b0;
    bank_num   = '0;
    unique case (in_data.opcode)
      OP_CPU_RD: begin
        if (in_data.bus_address[15]) begin
          acc_res.claimed = 1'b1;
          if (pc != '0) begin
            acc_res.target = TGT_PRG_RD;
            need_mod       = 1'b1;
            acc_is_prg     = 1'b1;
            case (in_data.bus_address[14:13])
              2'd0:    bank_num = bank_r[6] & MASK_1K;
              2'd1:    bank_num = bank_r[7] & MASK_1K;
              2'd2:    bank_num = (pc >= 9'd2) ? pc_m2[BANK_W-1:0] : '0;
              default: bank_num = pc_m1[BANK_W-1:0];
            endcase
          end
        end
      end
      OP_CPU_WR: begin
      end
      OP_PIC_RD, OP_PIC_WR: begin
        if (in_data.bus_address[15:13] == 3'd0 && cc != '0) begin
          need_mod = 1'b1;
          if (in_data.opcode == OP_PIC_RD) begin
            acc_res.claimed = 1'b1;
            acc_res.target  = TGT_CHR_RD;
          end else begin
            acc_res.target      = TGT_CHR_WR;
            acc_res.store_value = in_data.write_value;
          end
          case (in_data.bus_address[12:10])
            3'd0, 3'd1: bank_num = (bank_r[0] & MASK_2K) |
                                   {7'd0, in_data.bus_address[10]};
            3'd2, 3'd3: bank_num = (bank_r[1] & MASK_2K) |
                                   {7'd0, in_data.bus_address[10]};
            3'd4:       bank_num = bank_r[2] & MASK_1K;
            3'd5:       bank_num = bank_r[3] & MASK_1K;
            3'd6:       bank_num = bank_r[4] & MASK_1K;
            default:    bank_num = bank_r[5] & MASK_1K;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  cbm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire && need_mod),
    .dividend (bank_num),
    .divisor  (acc_is_prg ? pc : cc),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    fin_res = res_r;
    if (is_prg_r) begin
      fin_res.rom_offset = {mod_rem, off_lo_r};
    end else begin
      fin_res.rom_offset = {3'd0, mod_rem, off_lo_r[9:0]};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    bank_nxt      = bank_r;
    prg_cnt_nxt   = prg_cnt_r;
    chr_cnt_nxt   = chr_cnt_r;
    res_nxt       = res_r;
    is_prg_nxt    = is_prg_r;
    off_lo_nxt    = off_lo_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_valid) begin
      if (cfg_index == CFG_PRG_COUNT) begin
        prg_cnt_nxt = cfg_data;
      end else if (cfg_index == CFG_CHR_COUNT) begin
        chr_cnt_nxt = cfg_data;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_CPU_WR && in_data.bus_address[15]) begin
            if (!in_data.bus_address[0]) begin
              sel_nxt = in_data.write_value[2:0];
            end else begin
              bank_nxt[sel_r] = in_data.write_value;
            end
          end
          res_nxt    = acc_res;
          is_prg_nxt = acc_is_prg;
          off_lo_nxt = in_data.bus_address[12:0];
          state_nxt  = need_mod ? ST_RUN : ST_PUSH;
        end
      end
      ST_RUN: begin
        if (mod_done) begin
          if (out_free) begin
            out_nxt       = fin_res;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            res_nxt   = fin_res;
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= '0;
      bank_r      <= '{default: '0};
      prg_cnt_r   <= '0;
      chr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      bank_r      <= bank_nxt;
      prg_cnt_r   <= prg_cnt_nxt;
      chr_cnt_r   <= chr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r    <= res_nxt;
    is_prg_r <= is_prg_nxt;
    off_lo_r <= off_lo_nxt;
    out_r    <= out_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: design/cbm_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle.
module cbm_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cbm_pkg::BANK_W-1:0]  dividend,
  input  logic [cbm_pkg::COUNT_W-1:0] divisor,
  output logic                        done,
  output logic [cbm_pkg::BANK_W-1:0]  rem
);
  import cbm_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [BANK_W-1:0]   dvd_r, dvd_nxt;
  logic [COUNT_W-1:0]  div_r, div_nxt;
  logic [BANK_W-1:0]   rem_r, rem_nxt;
  logic [COUNT_W-1:0]  trial;
  logic [COUNT_W-1:0]  diff;

  assign trial = {rem_r, dvd_r[BANK_W-1]};
  assign diff  = trial - div_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= div_r) ? diff[BANK_W-1:0] : trial[BANK_W-1:0];
      dvd_nxt = {dvd_r[BANK_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: design/cbm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "cartridge_bank_mapper_assert.svh"

module cbm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input cbm_pkg::out_t out_data
);
  import cbm_pkg::*;

  `CBM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `CBM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `CBM_ASSERT_NOW(a_none_zero_offset, out_valid && out_data.target == TGT_NONE, out_data.rom_offset == '0)
  `CBM_ASSERT_NOW(a_store_only_chr_wr, out_valid && out_data.target != TGT_CHR_WR, out_data.store_value == '0)

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: tb/cartridge_bank_mapper_tb.sv
`timescale 1ns / 1ps

module cartridge_bank_mapper_tb;
  import cbm_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_TICKS = 14;
  localparam int PHASES       = 10;
  localparam int PHASE_BEATS  = 200;

  class access_scoreboard;
    cfg_data_t         prg_count;
    cfg_data_t         chr_count;
    logic [2:0]        select_reg;
    logic [BANK_W-1:0] banks [NUM_BANK_REGS];
    out_t              awaited[$];
    int                errors;

    function new();
      prg_count  = '0;
      chr_count  = '0;
      select_reg = '0;
      foreach (banks[i]) banks[i] = '0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    function int unsigned capped(cfg_data_t n);
      return (n > COUNT_MAX) ? COUNT_MAX : n;
    endfunction

    function void apply_register(cfg_index_t idx, cfg_data_t val);
      case (idx)
        CFG_PRG_COUNT: prg_count = val;
        CFG_CHR_COUNT: chr_count = val;
        default: ;
      endcase
    endfunction

    function void note_access(in_t acc);
      out_t        r;
      int unsigned pc, cc, a, prg_bank, chr_bank;
      r  = '0;
      pc = capped(prg_count);
      cc = capped(chr_count);
      a  = acc.bus_address;
      if (a < 'h0800)
        chr_bank = (banks[0] & MASK_2K) | ((a >> 10) & 1);
      else if (a < 'h1000)
        chr_bank = (banks[1] & MASK_2K) | ((a >> 10) & 1);
      else if (a < 'h1400)
        chr_bank = banks[2] & MASK_1K;
      else if (a < 'h1800)
        chr_bank = banks[3] & MASK_1K;
      else if (a < 'h1C00)
        chr_bank = banks[4] & MASK_1K;
      else
        chr_bank = banks[5] & MASK_1K;
      case (acc.opcode)
        OP_CPU_RD: begin
          if (a >= 'h8000) begin
            r.claimed = 1'b1;
            if (pc != 0) begin
              if (a <= 'h9FFF)
                prg_bank = banks[6] & MASK_1K;
              else if (a <= 'hBFFF)
                prg_bank = banks[7] & MASK_1K;
              else if (a <= 'hDFFF)
                prg_bank = (pc >= 2) ? pc - 2 : 0;
              else
                prg_bank = pc - 1;
              r.target     = TGT_PRG_RD;
              r.rom_offset = OFFSET_W'((prg_bank % pc) * 8192 + (a & 'h1FFF));
            end
          end
        end
        OP_CPU_WR: begin
          if (a >= 'h8000) begin
            if (!acc.bus_address[0])
              select_reg = acc.write_value[2:0];
            else
              banks[select_reg] = acc.write_value;
          end
        end
        OP_PIC_RD: begin
          if (a < 'h2000 && cc != 0) begin
            r.claimed    = 1'b1;
            r.target     = TGT_CHR_RD;
            r.rom_offset = OFFSET_W'((chr_bank % cc) * 1024 + (a & 'h03FF));
          end
        end
        default: begin
          if (a < 'h2000 && cc != 0) begin
            r.target      = TGT_CHR_WR;
            r.rom_offset  = OFFSET_W'((chr_bank % cc) * 1024 + (a & 'h03FF));
            r.store_value = acc.write_value;
          end
        end
      endcase
      awaited.push_back(r);
    endfunction

    task check_result(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result beat with nothing expected: %h", got));
        return;
      end
      want = awaited.pop_front();
      if (got.claimed !== want.claimed)
        report($sformatf("claimed %b, want %b", got.claimed, want.claimed));
      if (got.target !== want.target)
        report($sformatf("target %0d, want %0d", got.target, want.target));
      if (got.rom_offset !== want.rom_offset)
        report($sformatf("rom_offset %h, want %h", got.rom_offset, want.rom_offset));
      if (got.store_value !== want.store_value)
        report($sformatf("store_value %h, want %h", got.store_value, want.store_value));
    endtask

    task close();
      if (awaited.size() != 0)
        report($sformatf("%0d results never arrived", awaited.size()));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  access_scoreboard sb;
  logic      no_idle = 1'b0;
  int        cycles;
  cfg_data_t corner_counts [12] = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd7, 9'd8,
                                    9'd63, 9'd64, 9'd255, 9'd256, 9'd511};

  cartridge_bank_mapper uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int gap;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  function automatic in_t make_access(logic [1:0] op, logic [15:0] addr, logic [7:0] val);
    in_t acc;
    acc.opcode      = op;
    acc.bus_address = addr;
    acc.write_value = val;
    return acc;
  endfunction

  function automatic in_t random_read();
    in_t acc;
    acc.write_value = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: begin
        acc.opcode      = OP_CPU_RD;
        acc.bus_address = {1'b1, 15'($urandom)};
      end
      1: begin
        acc.opcode      = OP_PIC_RD;
        acc.bus_address = {3'b000, 13'($urandom)};
      end
      default: begin
        acc.opcode      = OP_PIC_WR;
        acc.bus_address = {3'b000, 13'($urandom)};
      end
    endcase
    return acc;
  endfunction

  function automatic cfg_data_t pick_count();
    if ($urandom_range(0, 1) == 0)
      return corner_counts[$urandom_range(0, 11)];
    return cfg_data_t'($urandom_range(0, 511));
  endfunction

  task automatic send_access(in_t acc);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= acc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_access(acc);
  endtask

  task automatic write_register(cfg_index_t idx, cfg_data_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_register(idx, val);
  endtask

  task automatic configure(cfg_data_t prg, cfg_data_t chr);
    write_register(CFG_PRG_COUNT, prg);
    write_register(CFG_CHR_COUNT, chr);
    write_register(cfg_index_t'($urandom_range(2, 255)), cfg_data_t'($urandom_range(0, 511)));
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic random_phase(int beats);
    int         k;
    logic [2:0] sel;
    k = 0;
    while (k < beats) begin
      if ($urandom_range(0, 3) != 0) begin
        sel = 3'($urandom_range(0, 7));
        send_access(make_access(OP_CPU_WR, {1'b1, 14'($urandom), 1'b0}, {5'($urandom), sel}));
        send_access(make_access(OP_CPU_WR, {1'b1, 14'($urandom), 1'b1}, 8'($urandom)));
        k += 2;
        repeat ($urandom_range(1, 4)) begin
          send_access(random_read());
          k++;
        end
      end else begin
        send_access(make_access(2'($urandom), 16'($urandom), 8'($urandom)));
        k++;
      end
    end
  endtask

  initial begin
    cfg_data_t prg, chr;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // no banks configured yet
    send_access(make_access(OP_CPU_RD, 16'h8000, 8'h00));
    send_access(make_access(OP_CPU_RD, 16'h7FFF, 8'h00));
    send_access(make_access(OP_PIC_WR, 16'h0000, 8'hFF));
    settle();

    // single program bank, full character space
    configure(9'd1, 9'd256);
    send_access(make_access(OP_CPU_WR, 16'h8000, 8'h06));
    send_access(make_access(OP_CPU_WR, 16'h8001, 8'hFF));
    send_access(make_access(OP_CPU_WR, 16'hFFFE, 8'hFF));
    send_access(make_access(OP_CPU_WR, 16'hFFFF, 8'h2A));
    send_access(make_access(OP_CPU_WR, 16'h7FFF, 8'h11));
    send_access(make_access(OP_CPU_RD, 16'h8000, 8'h00));
    send_access(make_access(OP_CPU_RD, 16'hA000, 8'h00));
    send_access(make_access(OP_CPU_RD, 16'hC000, 8'h00));
    send_access(make_access(OP_CPU_RD, 16'hFFFF, 8'h00));
    send_access(make_access(OP_CPU_WR, 16'h8000, 8'h00));
    send_access(make_access(OP_CPU_WR, 16'h8001, 8'h3F));
    send_access(make_access(OP_PIC_RD, 16'h0400, 8'h00));
    send_access(make_access(OP_PIC_RD, 16'h0C00, 8'h00));
    send_access(make_access(OP_PIC_RD, 16'h1000, 8'h00));
    send_access(make_access(OP_PIC_RD, 16'h1400, 8'h00));
    send_access(make_access(OP_PIC_RD, 16'h1800, 8'h00));
    send_access(make_access(OP_PIC_RD, 16'h1FFF, 8'h00));
    send_access(make_access(OP_PIC_RD, 16'h2000, 8'h00));
    send_access(make_access(OP_PIC_WR, 16'h1C00, 8'hA5));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin prg = 9'd511; chr = 9'd511; end
        1: begin prg = 9'd256; chr = 9'd0;   end
        2: begin prg = 9'd2;   chr = 9'd1;   end
        default: begin prg = pick_count(); chr = pick_count(); end
      endcase
      configure(prg, chr);
      no_idle = (p % 4 == 3);
      random_phase(PHASE_BEATS);
      settle();
    end

    sb.close();
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: cartridge_bank_mapper.f
+incdir+design
design/cbm_pkg.sv
design/cbm_mod.sv
design/cartridge_bank_mapper.sv
design/cbm_checker.sv
tb/cartridge_bank_mapper_tb.sv
